// File: src/relay_feedback_pid_autotuner_macros.svh
// assertion macros for the autotuner
`ifndef RELAY_FEEDBACK_PID_AUTOTUNER_MACROS_SVH
`define RELAY_FEEDBACK_PID_AUTOTUNER_MACROS_SVH

// property that must hold in the cycle after a trigger
`define RFA_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error(msg);

// property that must hold in the same cycle as a trigger
`define RFA_ASSERT_NOW(label, clk, rst_n, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
		else $error(msg);

`endif

// File: src/rfa_pkg.sv
package rfa_pkg;

	localparam int PeakSlots = 20;
	localparam int SlotW = 5;
	localparam int MaxCycles = 200;
	localparam int MaxTimeMs = 3600000;
	localparam int TimeW = 22;
	localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

	localparam logic [2:0] CfgSetpoint = 3'd0;
	localparam logic [2:0] CfgHighStep = 3'd1;
	localparam logic [2:0] CfgLowStep = 3'd2;
	localparam logic [2:0] CfgCrossing = 3'd3;
	localparam logic [2:0] CfgPidMode = 3'd4;
	localparam logic [2:0] CfgPosAction = 3'd5;
	localparam logic [2:0] CfgAmpLimit = 3'd6;
	localparam logic [2:0] CfgPerLimit = 3'd7;

	localparam logic [1:0] StStarting = 2'd0;
	localparam logic [1:0] StRunning = 2'd1;
	localparam logic [1:0] StFailed = 2'd2;
	localparam logic [1:0] StSucceeded = 2'd3;

	typedef enum logic [2:0] {
		PH_INIT = 3'd0,
		PH_START = 3'd1,
		PH_RUN = 3'd2,
		PH_FAIL = 3'd3,
		PH_SUCCESS = 3'd4
	} phase_t;

	// controller states, one-hot
	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_STEP = 8'b0000_0010,
		S_SUMA = 8'b0000_0100,
		S_SUMP = 8'b0000_1000,
		S_CMP = 8'b0001_0000,
		S_DIV = 8'b0010_0000,
		S_GAIN = 8'b0100_0000,
		S_OUT = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic start;
		logic [63:0] num;
		logic [63:0] den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [63:0] quo;
	} div_rsp_t;

	function automatic logic [7:0] sat_inc(input logic [7:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

endpackage

// File: src/rfa_divider.sv
module rfa_divider import rfa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input div_req_t req,
	output div_rsp_t rsp
);

	logic [63:0] rem_q, quo_q, den_q;
	logic [6:0] cnt_q;
	logic busy_q, done_q;
	logic [64:0] trial;

	assign trial = {rem_q, quo_q[63]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo = quo_q;

endmodule

// File: src/relay_feedback_pid_autotuner.sv
// a tick with no spread test or gain update goes through S_STEP and S_OUT to the result;
// a spread test adds the amplitude pass (S_SUMA, S_CMP) and, if it passes, the period pass
// (S_SUMP, S_CMP); a gain update adds S_GAIN and S_DIV, waiting on the 64-step serial divider
// unless the gain saturates. One tick in flight; the input stays stalled until the result
// transaction completes.
// reset: asynchronous; config, state, peak slots and gains take their reset values
`include "relay_feedback_pid_autotuner_macros.svh"
module relay_feedback_pid_autotuner import rfa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic signed [15:0] sample,
	input logic [15:0] elapsed_ms,
	output logic out_valid,
	input logic out_stall,
	output logic signed [15:0] drive,
	output logic [1:0] status,
	output logic [31:0] prop_gain,
	output logic [24:0] integral_time,
	output logic [21:0] derivative_time,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [15:0] cfg_data
);

	logic signed [15:0] setpoint_q, high_step_q, low_step_q;
	logic [7:0] crossing_q;
	logic pid_mode_q, pos_action_q;
	logic [15:0] amp_lim_q, per_lim_q;

	phase_t phase_q;
	state_t state_q;
	logic above_q;
	logic [TimeW-1:0] elapsed_q;
	logic [7:0] cycles_q, rise_q, fall_q, settle_q;
	logic [SlotW-1:0] slot_q;

	logic signed [15:0] maxv_q [PeakSlots];
	logic signed [15:0] minv_q [PeakSlots];
	logic [TimeW-1:0] maxt_q [PeakSlots];
	logic [TimeW-1:0] mint_q [PeakSlots];

	logic signed [15:0] held_q;
	logic [31:0] kp_q;
	logic [24:0] ti_q;
	logic [21:0] td_q;
	logic [1:0] status_q;
	logic out_valid_q;

	logic signed [15:0] smp_q;
	logic [15:0] el_q;

	logic [SlotW-1:0] idx_q;
	logic signed [28:0] sum_q;
	logic [63:0] sq_q;
	logic amp_ok_q;
	logic [63:0] den_q;
	logic kp_sat_q;

	div_req_t dreq;
	div_rsp_t drsp;

	rfa_divider u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(dreq),
		.rsp(drsp)
	);

	assign cfg_ready = (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE) || out_valid_q;
	assign out_valid = out_valid_q;
	assign drive = held_q;
	assign status = status_q;
	assign prop_gain = kp_q;
	assign integral_time = ti_q;
	assign derivative_time = td_q;

	wire signed [15:0] lvl_hi = pos_action_q ? high_step_q : low_step_q;
	wire signed [15:0] lvl_lo = pos_action_q ? low_step_q : high_step_q;

	// shared arithmetic unit operand for the spread walk
	logic signed [23:0] elem;
	logic [TimeW-1:0] half;
	always_comb begin
		half = mint_q[idx_q] - maxt_q[idx_q];
		if (state_q == S_SUMA)
			elem = 24'(maxv_q[idx_q]) - 24'(minv_q[idx_q]);
		else
			elem = {2'b00, half};
	end
	wire [23:0] elem_mag = elem[23] ? 24'(-elem) : elem;
	wire [47:0] elem_sq = elem_mag * elem_mag;

	wire [28:0] sum_mag = sum_q[28] ? 29'(-sum_q) : sum_q;
	wire [57:0] sum_sq = sum_mag * sum_mag;
	logic [63:0] spread, bound;
	logic [15:0] lim;
	always_comb begin
		lim = amp_ok_q ? per_lim_q : amp_lim_q;
		spread = 64'(PeakSlots) * sq_q - 64'(sum_sq);
		bound = 64'(PeakSlots * PeakSlots) * 64'(lim) * 64'(lim);
	end

	// gain operands
	wire [SlotW-1:0] prv = (slot_q == '0) ? SlotW'(PeakSlots - 1) : slot_q - 1'b1;
	wire signed [16:0] stepd = 17'(high_step_q) - 17'(low_step_q);
	wire signed [16:0] ampd = 17'(maxv_q[slot_q]) - 17'(minv_q[slot_q]);
	wire [16:0] step_mag = stepd[16] ? 17'(-stepd) : stepd;
	wire [16:0] amp_mag = ampd[16] ? 17'(-ampd) : ampd;
	wire [TimeW-1:0] tu = maxt_q[slot_q] - maxt_q[prv];

	always_comb begin
		dreq.start = 1'b0;
		dreq.num = 64'(step_mag) * (pid_mode_q ? 64'd6 : 64'd8) * 64'd2621440000;
		dreq.den = den_q;
		if (state_q == S_DIV && !drsp.busy && !drsp.done && !kp_sat_q) begin
			dreq.start = 1'b1;
			dreq.num = dreq.num + (den_q >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= '0;
			high_step_q <= 16'sd50;
			low_step_q <= '0;
			crossing_q <= 8'd5;
			pid_mode_q <= 1'b1;
			pos_action_q <= 1'b1;
			amp_lim_q <= '0;
			per_lim_q <= '0;
			phase_q <= PH_INIT;
			state_q <= S_IDLE;
			above_q <= 1'b1;
			elapsed_q <= '0;
			cycles_q <= '0;
			rise_q <= '0;
			fall_q <= '0;
			settle_q <= '0;
			slot_q <= '0;
			held_q <= '0;
			kp_q <= '0;
			ti_q <= '0;
			td_q <= '0;
			status_q <= StStarting;
			out_valid_q <= 1'b0;
			smp_q <= '0;
			el_q <= '0;
			idx_q <= '0;
			sum_q <= '0;
			sq_q <= '0;
			amp_ok_q <= 1'b0;
			den_q <= '0;
			kp_sat_q <= 1'b0;
			for (int i = 0; i < PeakSlots; i++) begin
				maxv_q[i] <= '0;
				minv_q[i] <= '0;
				maxt_q[i] <= '0;
				mint_q[i] <= '0;
			end
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CfgSetpoint: setpoint_q <= cfg_data;
					CfgHighStep: high_step_q <= cfg_data;
					CfgLowStep: low_step_q <= cfg_data;
					CfgCrossing: crossing_q <= cfg_data[7:0];
					CfgPidMode: pid_mode_q <= cfg_data[0];
					CfgPosAction: pos_action_q <= cfg_data[0];
					CfgAmpLimit: amp_lim_q <= cfg_data;
					CfgPerLimit: per_lim_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						smp_q <= sample;
						el_q <= elapsed_ms;
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					logic [TimeW:0] et;
					logic [7:0] r, f, st;
					logic [SlotW-1:0] sp_n;
					logic [7:0] cy;
					logic [TimeW-1:0] etot;
					et = {1'b0, elapsed_q} + (TimeW+1)'(el_q);
					etot = et[TimeW] ? TimeMax : et[TimeW-1:0];
					state_q <= S_OUT;
					case (phase_q)
						PH_START: begin
							elapsed_q <= etot;
							status_q <= StStarting;
							if (smp_q < setpoint_q) begin
								rise_q <= '0;
								f = sat_inc(fall_q);
								fall_q <= f;
								if (f >= crossing_q) held_q <= lvl_hi;
							end else begin
								fall_q <= '0;
								r = sat_inc(rise_q);
								rise_q <= r;
								if (r >= crossing_q) begin
									for (int k = 0; k < 3; k++) begin
										maxv_q[k] <= setpoint_q;
										minv_q[k] <= setpoint_q;
										maxt_q[k] <= '0;
										mint_q[k] <= '0;
									end
									phase_q <= PH_RUN;
								end
							end
						end
						PH_RUN: begin
							elapsed_q <= etot;
							status_q <= StRunning;
							cy = cycles_q;
							if (smp_q > setpoint_q) begin
								fall_q <= '0;
								r = sat_inc(rise_q);
								rise_q <= r;
								if (r >= crossing_q) begin
									held_q <= lvl_lo;
									sp_n = slot_q;
									if (!above_q) begin
										above_q <= 1'b1;
										settle_q <= '0;
										sp_n = (slot_q >= SlotW'(PeakSlots - 1)) ? '0 : slot_q + 1'b1;
										slot_q <= sp_n;
										maxv_q[sp_n] <= smp_q >= setpoint_q ? smp_q : setpoint_q;
										maxt_q[sp_n] <= smp_q >= setpoint_q ? etot : '0;
										minv_q[sp_n] <= setpoint_q;
										mint_q[sp_n] <= '0;
									end else if (smp_q >= maxv_q[sp_n]) begin
										maxv_q[sp_n] <= smp_q;
										maxt_q[sp_n] <= etot;
									end
								end
							end else begin
								rise_q <= '0;
								f = sat_inc(fall_q);
								fall_q <= f;
								if (f >= crossing_q) begin
									held_q <= lvl_hi;
									if (above_q) begin
										above_q <= 1'b0;
										cy = sat_inc(cycles_q);
										cycles_q <= cy;
									end
									st = settle_q;
									if (smp_q <= minv_q[slot_q]) begin
										minv_q[slot_q] <= smp_q;
										mint_q[slot_q] <= etot;
										st = 8'd1;
									end else if (settle_q != 0) begin
										st = sat_inc(settle_q);
									end
									settle_q <= st;
									if (cy >= 8'(PeakSlots) && st >= crossing_q) begin
										state_q <= S_SUMA;
										idx_q <= '0;
										sum_q <= '0;
										sq_q <= '0;
									end
								end
							end
							if (cy > 8'(MaxCycles) || etot > TimeW'(MaxTimeMs))
								phase_q <= PH_FAIL;
						end
						PH_FAIL, PH_SUCCESS: begin
							elapsed_q <= etot;
							status_q <= (phase_q == PH_FAIL) ? StFailed : StSucceeded;
							den_q <= 64'd314159 * 64'(amp_mag);
							kp_sat_q <= 1'b0;
							state_q <= S_GAIN;
						end
						default: begin
							status_q <= StStarting;
							elapsed_q <= '0;
							cycles_q <= '0;
							rise_q <= '0;
							fall_q <= '0;
							above_q <= 1'b1;
							slot_q <= '0;
							held_q <= (smp_q <= setpoint_q) ? lvl_hi : lvl_lo;
							phase_q <= PH_START;
						end
					endcase
				end
				S_SUMA, S_SUMP: begin
					sum_q <= sum_q + 29'(elem);
					sq_q <= sq_q + 64'(elem_sq);
					idx_q <= idx_q + 1'b1;
					if (idx_q == SlotW'(PeakSlots - 1)) state_q <= S_CMP;
				end
				S_CMP: begin
					// spread and bound use the limit of the pass just finished
					if (!amp_ok_q) begin
						if (spread < bound) begin
							amp_ok_q <= 1'b1;
							idx_q <= '0;
							sum_q <= '0;
							sq_q <= '0;
							state_q <= S_SUMP;
						end else begin
							state_q <= S_OUT;
						end
					end else begin
						amp_ok_q <= 1'b0;
						if (spread < bound && phase_q == PH_RUN) phase_q <= PH_SUCCESS;
						state_q <= S_OUT;
					end
				end
				S_GAIN: begin
					ti_q <= 25'(tu) << 2;
					td_q <= tu;
					if (ampd == 0) begin
						kp_q <= 32'hFFFF_FFFF;
						kp_sat_q <= 1'b1;
					end else if (stepd == 0 || (stepd[16] != ampd[16])) begin
						kp_q <= '0;
						kp_sat_q <= 1'b1;
					end
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (kp_sat_q) begin
						state_q <= S_OUT;
					end else if (drsp.done) begin
						kp_q <= (drsp.quo[63:32] != 0) ? 32'hFFFF_FFFF : drsp.quo[31:0];
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (phase_q == PH_FAIL && status_q != StRunning
						|| phase_q == PH_SUCCESS && status_q != StRunning) begin
						elapsed_q <= '0;
						cycles_q <= '0;
						rise_q <= '0;
						fall_q <= '0;
						above_q <= 1'b1;
						slot_q <= '0;
						held_q <= lvl_lo;
						phase_q <= PH_INIT;
					end
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`RFA_ASSERT_NOW(a_onehot, clk, arst_n, 1'b1, $onehot(state_q), "state not one-hot")
	`RFA_ASSERT_NOW(a_no_accept_busy, clk, arst_n, state_q != S_IDLE, in_stall, "input taken while busy")
	`RFA_ASSERT_NEXT(a_out_after, clk, arst_n, state_q == S_OUT, out_valid, "result not shown")
	`RFA_ASSERT_NOW(a_cfg_idle, clk, arst_n, cfg_ready, state_q == S_IDLE, "config while busy")

endmodule
